/* rtl/rpf_pkg.sv */
package rpf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_VINIT,
    ST_ROT,
    ST_MULX,
    ST_RNDX,
    ST_MULY,
    ST_RNDY,
    ST_SAT,
    ST_EMIT0,
    ST_EMIT1,
    ST_EMIT2,
    ST_NEXT
  } rpf_state_t;

  typedef enum logic [1:0] {
    CORNER_FIRST = 2'd0,
    CORNER_PREV  = 2'd1,
    CORNER_CUR   = 2'd2
  } rpf_corner_t;

  typedef struct packed {
    logic        load_req;
    logic        cnt_clear;
    logic        div_step;
    logic        vtx_init;
    logic        rot_step;
    logic        mul_x;
    logic        rnd_x;
    logic        mul_y;
    logic        rnd_y;
    logic        sat;
    logic        vtx_next;
    logic        emit;
    rpf_corner_t emit_corner;
  } rpf_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic div_last;
    logic rot_last;
    logic k_ge2;
    logic k_last;
    logic out_free;
  } rpf_status_t;

  // CORDIC start vector: inverse of the limit gain in Q4.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/rpf_datapath.sv */
module rpf_datapath #(
  parameter int MAX_SIDES    = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rpf_pkg::rpf_cmd_t   cmd,
  output rpf_pkg::rpf_status_t status,
  input  logic [31:0]         center_x,
  input  logic [31:0]         center_y,
  input  logic [30:0]         radius,
  input  logic [4:0]          side_count,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [3:0]          out_tri,
  output logic [1:0]          out_corner,
  output logic [31:0]         out_x,
  output logic [31:0]         out_y,
  output logic                out_last
);

  localparam int CNT_MAX = (ANGLE_BITS + 1 > CORDIC_STEPS) ? ANGLE_BITS + 1 : CORDIC_STEPS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam logic [4:0] MAX_N = 5'(MAX_SIDES);

  // request
  logic signed [31:0] cx, cy;
  logic [30:0]        r;
  logic [4:0]         n;
  logic [4:0]         k;
  logic [CNT_W-1:0]   cnt;

  // phase step 2^ANGLE_BITS / n and its accumulator
  logic [ANGLE_BITS-1:0] qv, qacc;
  logic [4:0]            rv, racc;

  // CORDIC
  logic [1:0]         quad;
  logic signed [33:0] x, y;
  logic signed [32:0] z;
  logic signed [33:0] cq, sq, ma;
  logic signed [65:0] prod;
  logic signed [35:0] off_x, off_y;
  logic [31:0]        cur_x, cur_y, first_x, first_y, prev_x, prev_y;

  logic [5:0]        rem_sh, rsum;
  logic              ge, wrap;
  logic [31:0]       phase;
  logic signed [32:0] at;

  assign rem_sh = {rv, (cnt == CNT_W'(0))};
  assign ge     = rem_sh >= {1'b0, n};
  assign rsum   = {1'b0, racc} + {1'b0, rv};
  assign wrap   = rsum >= {1'b0, n};
  assign phase  = {qacc, {(32 - ANGLE_BITS){1'b0}}};
  assign at     = $signed({3'b000, rpf_pkg::atan_turn(5'(cnt))});

  always_comb begin
    case (quad)
      2'd0:    begin cq = x;  sq = y;  end
      2'd1:    begin cq = -y; sq = x;  end
      2'd2:    begin cq = -x; sq = -y; end
      default: begin cq = y;  sq = -x; end
    endcase
    ma = cmd.mul_x ? cq : sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= '0;
      k    <= '0;
      cnt  <= '0;
      racc <= '0;
      qacc <= '0;
    end else begin
      if (cmd.load_req) begin
        n    <= (side_count > MAX_N) ? MAX_N : side_count;
        k    <= '0;
        qacc <= '0;
        racc <= '0;
      end
      if (cmd.load_req || cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.div_step || cmd.rot_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.vtx_next) begin
        k    <= k + 5'd1;
        racc <= wrap ? 5'(rsum - {1'b0, n}) : rsum[4:0];
        qacc <= qacc + qv + ANGLE_BITS'(wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cx <= center_x;
      cy <= center_y;
      r  <= radius;
      qv <= '0;
      rv <= '0;
    end
    // restoring divide, one quotient bit per step
    if (cmd.div_step) begin
      rv <= ge ? 5'(rem_sh - {1'b0, n}) : rem_sh[4:0];
      qv <= {qv[ANGLE_BITS-2:0], ge};
    end
    if (cmd.vtx_init) begin
      quad <= phase[31:30];
      z    <= $signed({3'b000, phase[29:0]});
      x    <= rpf_pkg::CORDIC_X0;
      y    <= '0;
    end
    if (cmd.rot_step) begin
      if (!z[32]) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - at;
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + at;
      end
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= $signed({1'b0, r}) * ma;
    end
    if (cmd.rnd_x) begin
      off_x <= 36'((prod + 66'sd536870912) >>> 30);
    end
    if (cmd.rnd_y) begin
      off_y <= 36'((prod + 66'sd536870912) >>> 30);
    end
    if (cmd.sat) begin
      cur_x <= rpf_pkg::sat32(37'(cx) + 37'(off_x));
      cur_y <= rpf_pkg::sat32(37'(cy) + 37'(off_y));
    end
    if (cmd.vtx_next) begin
      if (k == 5'd0) begin
        first_x <= cur_x;
        first_y <= cur_y;
      end
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tri    <= 4'(k - 5'd2);
      out_corner <= cmd.emit_corner;
      out_last   <= (cmd.emit_corner == rpf_pkg::CORNER_CUR) && status.k_last;
      case (cmd.emit_corner)
        rpf_pkg::CORNER_FIRST: begin out_x <= first_x; out_y <= first_y; end
        rpf_pkg::CORNER_PREV:  begin out_x <= prev_x;  out_y <= prev_y;  end
        default:               begin out_x <= cur_x;   out_y <= cur_y;   end
      endcase
    end
  end

  assign status.req_ok   = side_count >= 5'd3;
  assign status.div_last = cnt == CNT_W'(ANGLE_BITS);
  assign status.rot_last = cnt == CNT_W'(CORDIC_STEPS - 1);
  assign status.k_ge2    = k >= 5'd2;
  assign status.k_last   = k == (n - 5'd1);
  assign status.out_free = !out_valid || out_ready;

  a_racc_below_n: assert property (@(posedge clk) disable iff (rst)
    (n == 5'd0) || (racc < n))
    else $error("phase remainder not below side count");
  a_last_on_corner2: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_corner == rpf_pkg::CORNER_CUR)
    else $error("last flag on a corner other than the closing one");
  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable({out_tri, out_corner, out_x, out_y, out_last}))
    else $error("waiting beat changed before it was taken");

endmodule

/* rtl/rpf_ctrl.sv */
module rpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rpf_pkg::rpf_status_t status,
  output rpf_pkg::rpf_cmd_t    cmd
);

  rpf_pkg::rpf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rpf_pkg::ST_IDLE:  if (in_valid && status.req_ok) state_next = rpf_pkg::ST_DIV;
      rpf_pkg::ST_DIV:   if (status.div_last) state_next = rpf_pkg::ST_VINIT;
      rpf_pkg::ST_VINIT: state_next = rpf_pkg::ST_ROT;
      rpf_pkg::ST_ROT:   if (status.rot_last) state_next = rpf_pkg::ST_MULX;
      rpf_pkg::ST_MULX:  state_next = rpf_pkg::ST_RNDX;
      rpf_pkg::ST_RNDX:  state_next = rpf_pkg::ST_MULY;
      rpf_pkg::ST_MULY:  state_next = rpf_pkg::ST_RNDY;
      rpf_pkg::ST_RNDY:  state_next = rpf_pkg::ST_SAT;
      rpf_pkg::ST_SAT:   state_next = status.k_ge2 ? rpf_pkg::ST_EMIT0 : rpf_pkg::ST_NEXT;
      rpf_pkg::ST_EMIT0: if (status.out_free) state_next = rpf_pkg::ST_EMIT1;
      rpf_pkg::ST_EMIT1: if (status.out_free) state_next = rpf_pkg::ST_EMIT2;
      rpf_pkg::ST_EMIT2: if (status.out_free) state_next = rpf_pkg::ST_NEXT;
      rpf_pkg::ST_NEXT:  state_next = status.k_last ? rpf_pkg::ST_IDLE : rpf_pkg::ST_VINIT;
      default:           state_next = rpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_corner = rpf_pkg::CORNER_FIRST;
    in_ready        = 1'b0;
    case (state)
      rpf_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid && status.req_ok;
      end
      rpf_pkg::ST_DIV:   cmd.div_step = 1'b1;
      rpf_pkg::ST_VINIT: begin
        cmd.vtx_init  = 1'b1;
        cmd.cnt_clear = 1'b1;
      end
      rpf_pkg::ST_ROT:   cmd.rot_step = 1'b1;
      rpf_pkg::ST_MULX:  cmd.mul_x = 1'b1;
      rpf_pkg::ST_RNDX:  cmd.rnd_x = 1'b1;
      rpf_pkg::ST_MULY:  cmd.mul_y = 1'b1;
      rpf_pkg::ST_RNDY:  cmd.rnd_y = 1'b1;
      rpf_pkg::ST_SAT:   cmd.sat = 1'b1;
      rpf_pkg::ST_EMIT0: begin
        cmd.emit        = status.out_free;
        cmd.emit_corner = rpf_pkg::CORNER_FIRST;
      end
      rpf_pkg::ST_EMIT1: begin
        cmd.emit        = status.out_free;
        cmd.emit_corner = rpf_pkg::CORNER_PREV;
      end
      rpf_pkg::ST_EMIT2: begin
        cmd.emit        = status.out_free;
        cmd.emit_corner = rpf_pkg::CORNER_CUR;
      end
      rpf_pkg::ST_NEXT:  cmd.vtx_next = 1'b1;
      default: ;
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("beat loaded over a waiting beat");
  a_rot_exit: assert property (@(posedge clk) disable iff (rst)
    state == rpf_pkg::ST_ROT |=> state == rpf_pkg::ST_ROT || state == rpf_pkg::ST_MULX)
    else $error("rotation left to an unexpected state");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != rpf_pkg::ST_IDLE |-> !in_ready)
    else $error("request taken while busy");

endmodule

/* rtl/regular_polygon_fan_generator.sv */
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: center_x[31:0] center_y[63:32] radius[94:64] side_count[99:95]
// m_axis    out  tdata: triangle_index[3:0] corner[5:4] vertex_x[37:6] vertex_y[69:38];
//                tlast: last
//
// One request at a time. Setup is a bit-serial phase step divide, then
// each vertex runs CORDIC (one micro-rotation per cycle) and scaling (one
// shared multiplier used for x then y), plus three beats for every vertex
// from the third on. A stalled m_axis holds the sequencer at its next beat.
// A side_count below 3 is taken and dropped.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
module regular_polygon_fan_generator #(
  parameter int MAX_SIDES    = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, radius, side_count, zero pad
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // triangle_index, corner, vertex_x, vertex_y, zero pad
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  rpf_pkg::rpf_cmd_t    cmd;
  rpf_pkg::rpf_status_t status;

  logic [3:0]  out_tri;
  logic [1:0]  out_corner;
  logic [31:0] out_x, out_y;

  // sequence setup, rotation, scaling and the three beats of each triangle
  rpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rpf_datapath #(
    .MAX_SIDES    (MAX_SIDES),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .center_x   (s_axis_tdata[31:0]),
    .center_y   (s_axis_tdata[63:32]),
    .radius     (s_axis_tdata[94:64]),
    .side_count (s_axis_tdata[99:95]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_tri    (out_tri),
    .out_corner (out_corner),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_last   (m_axis_tlast)
  );

  // pack the beat, zero pad to whole bytes
  assign m_axis_tdata = {2'b00, out_y, out_x, out_corner, out_tri};

endmodule
